// File: hw/rtl/hbc_pkg.sv
// shared types and constants for the hit coincidence builder
package hbc_pkg;
	localparam int WINDOW_DEPTH = 4;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W = $clog2(WINDOW_DEPTH);

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_SLOPE  = 2'd1;
	localparam logic [1:0] REG_SHIFT  = 2'd2;

	localparam logic [2:0] KIND_RAW  = 3'd0;
	localparam logic [2:0] KIND_CAL  = 3'd1;
	localparam logic [2:0] KIND_PAIR = 3'd2;
	localparam logic [2:0] KIND_JSUM = 3'd3;
	localparam logic [2:0] KIND_TWOD = 3'd4;
	localparam logic [2:0] KIND_TRI  = 3'd5;

	localparam logic [2:0] PAIR_CHANNEL = 3'd2;

	typedef struct packed {
		logic [63:0] hit_time;
		logic [2:0]  channel;
		logic [14:0] charge;
	} cell_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_MORE, ST_RAW, ST_CAL, ST_PAIR0, ST_PAIR1,
		ST_JSUM, ST_TWOD, ST_TRI0, ST_TRI1, ST_TRI2, ST_SHIFT, ST_STORE
	} state_t;
endpackage

// File: hw/rtl/hbc_if.sv
// channel interfaces for hits, fill records and register writes
interface hbc_hit_if;
	logic        valid;
	logic        ready;
	logic [63:0] hit_time;
	logic [2:0]  hit_channel;
	logic [14:0] hit_charge;
	modport source (output valid, hit_time, hit_channel, hit_charge, input ready);
	modport sink (input valid, hit_time, hit_channel, hit_charge, output ready);
endinterface

interface hbc_fill_if;
	logic        valid;
	logic        ready;
	logic [2:0]  fill_kind;
	logic [1:0]  spectrum_index;
	logic [16:0] value_x;
	logic [15:0] value_y;
	logic        last;
	modport source (output valid, fill_kind, spectrum_index, value_x, value_y, last,
		input ready);
	modport sink (input valid, fill_kind, spectrum_index, value_x, value_y, last,
		output ready);
endinterface

interface hbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/detector_hit_coincidence_builder.sv
// top level: pending hit row and fill record sequencer
//
//  port  | dir | word
//  hit   | in  | hit_time, hit_channel, hit_charge
//  fill  | out | fill_kind, spectrum_index, value_x, value_y, last
//  cfg   | in  | index, data (window, slope, shift)
//
// each anchor that a hit closes, by time or forced by a full row, emits a raw
// and a calibrated record per buffered hit, plus two pair records or five
// triple records, one record per cycle from the single output register.
// a stalled fill word holds the sequencer.
// reset empties the row and loads the register defaults; no clearing pass.
module detector_hit_coincidence_builder (
	input  logic clk,
	input  logic arst_n,
	hbc_hit_if.sink    hit,
	hbc_fill_if.source fill,
	hbc_cfg_if.sink    cfg
);
	import hbc_pkg::*;

	state_t state_q, state_d;

	logic [31:0] window_q;
	logic [16:0] slope_q;
	logic [30:0] shift_q;

	logic [63:0]      t_q;
	logic [2:0]       ch_q;
	logic [14:0]      chg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] j_q;
	logic             more_q, pair_q, tri_q, forced_q;
	logic [2:0]       sch_q [3];
	logic [14:0]      sq_q [3];
	logic [31:0]      prod_q;

	logic        out_v_q;
	logic [2:0]  kind_q;
	logic [1:0]  idx_q;
	logic [16:0] x_q;
	logic [15:0] y_q;
	logic        last_q;

	cell_t cells [WINDOW_DEPTH];
	cell_t din;

	assign din = '{hit_time: t_q, channel: ch_q, charge: chg_q};

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_row
		hbc_cell u_cell (
			.clk   (clk),
			.shift (state_q == ST_SHIFT),
			.load  (state_q == ST_STORE && cnt_q == CNT_W'(i)),
			.nb    (cells[(i + 1 < WINDOW_DEPTH) ? i + 1 : i]),
			.din   (din),
			.q     (cells[i])
		);
	end

	// window tests
	logic [63:0] diff0, diff1;
	logic        close0, close1;
	assign diff0  = t_q - cells[0].hit_time;
	assign diff1  = t_q - cells[1].hit_time;
	assign close0 = diff0 >= {32'd0, window_q};
	assign close1 = diff1 >= {32'd0, window_q};

	// three-hit sort by channel
	logic [2:0]  c0, c1, c2, tc;
	logic [14:0] k0, k1, k2, tk;
	always_comb begin
		tc = '0;
		tk = '0;
		c0 = cells[0].channel; k0 = cells[0].charge;
		c1 = cells[1].channel; k1 = cells[1].charge;
		c2 = cells[2].channel; k2 = cells[2].charge;
		if (c0 > c1) begin
			tc = c0; c0 = c1; c1 = tc; tk = k0; k0 = k1; k1 = tk;
		end
		if (c1 > c2) begin
			tc = c1; c1 = c2; c2 = tc; tk = k1; k1 = k2; k2 = tk;
		end
		if (c0 > c1) begin
			tc = c0; c0 = c1; c1 = tc; tk = k0; k0 = k1; k1 = tk;
		end
	end

	logic go;
	logic j_end;
	cell_t cur;
	assign go    = !out_v_q || fill.ready;
	assign cur   = cells[j_q];
	assign j_end = (j_q == IDX_W'(cnt_q - CNT_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (hit.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if ((cnt_q != '0 && close0) || cnt_q == CNT_W'(WINDOW_DEPTH))
					state_d = ST_MORE;
				else
					state_d = ST_STORE;
			end
			ST_MORE:  state_d = ST_RAW;
			ST_RAW:   if (go) state_d = ST_CAL;
			ST_CAL: begin
				if (go) begin
					if (!j_end) state_d = ST_RAW;
					else if (pair_q) state_d = ST_PAIR0;
					else if (tri_q) state_d = ST_JSUM;
					else state_d = ST_SHIFT;
				end
			end
			ST_PAIR0: if (go) state_d = ST_PAIR1;
			ST_PAIR1: if (go) state_d = ST_SHIFT;
			ST_JSUM:  if (go) state_d = ST_TWOD;
			ST_TWOD:  if (go) state_d = ST_TRI0;
			ST_TRI0:  if (go) state_d = ST_TRI1;
			ST_TRI1:  if (go) state_d = ST_TRI2;
			ST_TRI2:  if (go) state_d = ST_SHIFT;
			// a forced close is the last close of a hit
			ST_SHIFT: state_d = forced_q ? ST_STORE : ST_CHECK;
			ST_STORE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// record contents
	logic        emit;
	logic [2:0]  r_kind;
	logic [1:0]  r_idx;
	logic [16:0] r_x;
	logic [15:0] r_y;
	logic        r_end;
	logic [32:0] cal_sum;
	logic [15:0] jsum;
	assign cal_sum = 33'(shift_q) + 33'(prod_q);
	assign jsum    = 16'(sq_q[0]) + 16'(sq_q[2]);

	always_comb begin
		emit   = 1'b1;
		r_kind = KIND_RAW;
		r_idx  = cur.channel[2:1];
		r_x    = 17'(cur.charge);
		r_y    = '0;
		r_end  = 1'b0;
		unique case (state_q)
			ST_RAW: ;
			ST_CAL: begin
				r_kind = KIND_CAL;
				r_x    = cal_sum[32:16];
				r_end  = j_end && !pair_q && !tri_q;
			end
			ST_PAIR0: begin
				r_kind = KIND_PAIR;
				r_idx  = cells[0].channel[2:1];
				r_x    = 17'(cells[0].charge);
			end
			ST_PAIR1: begin
				r_kind = KIND_PAIR;
				r_idx  = cells[1].channel[2:1];
				r_x    = 17'(cells[1].charge);
				r_end  = 1'b1;
			end
			ST_JSUM: begin
				r_kind = KIND_JSUM;
				r_idx  = '0;
				r_x    = 17'(jsum);
			end
			ST_TWOD: begin
				r_kind = KIND_TWOD;
				r_idx  = '0;
				r_x    = 17'(sq_q[1]);
				r_y    = jsum;
			end
			ST_TRI0: begin
				r_kind = KIND_TRI;
				r_idx  = sch_q[0][2:1];
				r_x    = 17'(sq_q[0]);
			end
			ST_TRI1: begin
				r_kind = KIND_TRI;
				r_idx  = sch_q[1][2:1];
				r_x    = 17'(sq_q[1]);
			end
			ST_TRI2: begin
				r_kind = KIND_TRI;
				r_idx  = sch_q[2][2:1];
				r_x    = 17'(sq_q[2]);
				r_end  = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
			window_q <= 32'd400000;
			slope_q  <= 17'd26951;
			shift_q  <= 31'd12000625;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_WINDOW: window_q <= cfg.data;
					REG_SLOPE:  slope_q <= cfg.data[16:0];
					REG_SHIFT:  shift_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			if (state_q == ST_SHIFT) cnt_q <= cnt_q - CNT_W'(1);
			if (state_q == ST_STORE) cnt_q <= cnt_q + CNT_W'(1);
			if (emit && go) out_v_q <= 1'b1;
			else if (fill.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && hit.valid) begin
			t_q   <= hit.hit_time;
			ch_q  <= hit.hit_channel;
			chg_q <= hit.hit_charge;
		end
		if (state_q == ST_MORE) begin
			forced_q <= !close0;
			more_q   <= close0 && (cnt_q > CNT_W'(1)) && close1;
			pair_q   <= (cnt_q == CNT_W'(2)) &&
				(cells[0].channel == PAIR_CHANNEL || cells[1].channel == PAIR_CHANNEL);
			tri_q    <= (cnt_q == CNT_W'(3)) && (c0 != c1) && (c1 != c2) && (c0 != c2);
			sch_q[0] <= c0; sch_q[1] <= c1; sch_q[2] <= c2;
			sq_q[0]  <= k0; sq_q[1]  <= k1; sq_q[2]  <= k2;
			j_q      <= '0;
		end
		if (state_q == ST_RAW && go) prod_q <= slope_q * 32'(cur.charge);
		if (state_q == ST_CAL && go && !j_end) j_q <= j_q + IDX_W'(1);
		if (emit && go) begin
			kind_q <= r_kind;
			idx_q  <= r_idx;
			x_q    <= r_x;
			y_q    <= r_y;
			last_q <= r_end && !more_q;
		end
	end

	assign hit.ready           = (state_q == ST_IDLE);
	assign cfg.ready           = 1'b1;
	assign fill.valid          = out_v_q;
	assign fill.fill_kind      = kind_q;
	assign fill.spectrum_index = idx_q;
	assign fill.value_x        = x_q;
	assign fill.value_y        = y_q;
	assign fill.last           = last_q;
endmodule

// File: hw/rtl/hbc_cell.sv
// one buffered hit of the pending row, shifts toward the anchor on close
module hbc_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          load,
	input  hbc_pkg::cell_t nb,
	input  hbc_pkg::cell_t din,
	output hbc_pkg::cell_t q
);
	import hbc_pkg::*;

	cell_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= nb;
		end else if (load) begin
			data_q <= din;
		end
	end

	assign q = data_q;
endmodule

// File: sim/detector_hit_coincidence_builder_tb.sv
// testbench for the hit coincidence builder: predicts fill words per hit and checks them in order
module detector_hit_coincidence_builder_tb;
	import hbc_pkg::*;

	typedef struct packed {
		logic [63:0] hit_time;
		logic [2:0]  hit_channel;
		logic [14:0] hit_charge;
	} hit_word_t;

	typedef struct packed {
		logic [2:0]  fill_kind;
		logic [1:0]  spectrum_index;
		logic [16:0] value_x;
		logic [15:0] value_y;
		logic        last;
	} fill_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hbc_hit_if  hit ();
	hbc_fill_if fill ();
	hbc_cfg_if  cfg ();

	detector_hit_coincidence_builder u_top (
		.clk(clk), .arst_n(arst_n), .hit(hit.sink), .fill(fill.source), .cfg(cfg.sink)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [31:0] win_ps = 32'd400000;
	logic [16:0] slope_q16 = 17'd26951;
	logic [30:0] shift_q16 = 31'd12000625;
	logic [63:0] row_time [WINDOW_DEPTH];
	logic [2:0]  row_chan [WINDOW_DEPTH];
	logic [14:0] row_charge [WINDOW_DEPTH];
	int row_count = 0;

	hit_word_t  hit_queue[$];
	fill_word_t fill_expected[$];
	int errors = 0;
	int hits_sent = 0;
	int fills_seen = 0;
	int triples_seen = 0;
	int pairs_seen = 0;
	bit hold_sender = 1'b0;
	bit long_stall = 1'b0;

	function automatic fill_word_t make_fill(logic [2:0] k, logic [1:0] si,
		logic [16:0] x, logic [15:0] y);
		fill_word_t f;
		f.fill_kind = k;
		f.spectrum_index = si;
		f.value_x = x;
		f.value_y = y;
		f.last = 1'b0;
		return f;
	endfunction

	function automatic void add_expected(fill_word_t f);
		fill_expected = {fill_expected, f};
	endfunction

	function automatic logic [16:0] calibrate(logic [14:0] q);
		logic [63:0] acc;
		acc = 64'(shift_q16) + 64'(slope_q16) * 64'(q);
		return acc[32:16];
	endfunction

	task automatic close_anchor();
		int j;
		logic [2:0] c [3];
		logic [14:0] q [3];
		logic [2:0] tc;
		logic [14:0] tq;
		logic [16:0] jsum;
		for (j = 0; j < row_count; j++) begin
			add_expected(make_fill(KIND_RAW, row_chan[j][2:1], 17'(row_charge[j]), '0));
			add_expected(make_fill(KIND_CAL, row_chan[j][2:1],
				calibrate(row_charge[j]), '0));
		end
		if (row_count == 2 && (row_chan[0] == PAIR_CHANNEL || row_chan[1] == PAIR_CHANNEL)) begin
			pairs_seen++;
			for (j = 0; j < 2; j++)
				add_expected(make_fill(KIND_PAIR, row_chan[j][2:1],
					17'(row_charge[j]), '0));
		end else if (row_count == 3 && row_chan[0] != row_chan[1]
			&& row_chan[0] != row_chan[2] && row_chan[1] != row_chan[2]) begin
			triples_seen++;
			for (j = 0; j < 3; j++) begin
				c[j] = row_chan[j];
				q[j] = row_charge[j];
			end
			if (c[0] > c[1]) begin tc = c[0]; c[0] = c[1]; c[1] = tc; tq = q[0]; q[0] = q[1]; q[1] = tq; end
			if (c[1] > c[2]) begin tc = c[1]; c[1] = c[2]; c[2] = tc; tq = q[1]; q[1] = q[2]; q[2] = tq; end
			if (c[0] > c[1]) begin tc = c[0]; c[0] = c[1]; c[1] = tc; tq = q[0]; q[0] = q[1]; q[1] = tq; end
			jsum = 17'(q[0]) + 17'(q[2]);
			add_expected(make_fill(KIND_JSUM, '0, jsum, '0));
			add_expected(make_fill(KIND_TWOD, '0, 17'(q[1]), jsum[15:0]));
			for (j = 0; j < 3; j++)
				add_expected(make_fill(KIND_TRI, c[j][2:1], 17'(q[j]), '0));
		end
		for (j = 0; j < row_count - 1; j++) begin
			row_time[j] = row_time[j + 1];
			row_chan[j] = row_chan[j + 1];
			row_charge[j] = row_charge[j + 1];
		end
		row_count--;
	endtask

	task automatic predict_hit(hit_word_t h);
		int n_prior;
		n_prior = fill_expected.size();
		while (row_count > 0 && (h.hit_time - row_time[0]) >= 64'(win_ps))
			close_anchor();
		if (row_count >= WINDOW_DEPTH)
			close_anchor();
		row_time[row_count] = h.hit_time;
		row_chan[row_count] = h.hit_channel;
		row_charge[row_count] = h.hit_charge;
		row_count++;
		if (fill_expected.size() > n_prior)
			fill_expected[$].last = 1'b1;
	endtask

	// driver
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit.valid <= 1'b0;
			hit.hit_time <= '0;
			hit.hit_channel <= '0;
			hit.hit_charge <= '0;
			gap = 0;
		end else begin
			if (hit.valid && hit.ready) begin
				predict_hit({hit.hit_time, hit.hit_channel, hit.hit_charge});
				hits_sent++;
			end
			if (hit.valid && !hit.ready) begin
			end else if (gap > 0 || hold_sender || hit_queue.size() == 0) begin
				hit.valid <= 1'b0;
				if (gap > 0)
					gap--;
			end else begin
				hit_word_t h;
				h = hit_queue.pop_front();
				hit.valid <= 1'b1;
				hit.hit_time <= h.hit_time;
				hit.hit_channel <= h.hit_channel;
				hit.hit_charge <= h.hit_charge;
				if (!long_stall && $urandom_range(0, 3) == 0)
					gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
		end
	end

	// monitor
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill.ready <= 1'b0;
			stall = 0;
		end else begin
			if (fill.valid && fill.ready) begin
				fill_word_t exp_w;
				fills_seen++;
				if (fill_expected.size() == 0) begin
					errors++;
					$error("fill word with nothing expected: kind %0d x %0d", fill.fill_kind,
						fill.value_x);
				end else begin
					exp_w = fill_expected.pop_front();
					if (fill.fill_kind !== exp_w.fill_kind) begin
						errors++;
						$error("fill_kind exp %0d got %0d", exp_w.fill_kind, fill.fill_kind);
					end
					if (fill.spectrum_index !== exp_w.spectrum_index) begin
						errors++;
						$error("spectrum_index exp %0d got %0d", exp_w.spectrum_index,
							fill.spectrum_index);
					end
					if (fill.value_x !== exp_w.value_x) begin
						errors++;
						$error("value_x exp %0d got %0d", exp_w.value_x, fill.value_x);
					end
					if (fill.value_y !== exp_w.value_y) begin
						errors++;
						$error("value_y exp %0d got %0d", exp_w.value_y, fill.value_y);
					end
					if (fill.last !== exp_w.last) begin
						errors++;
						$error("last exp %0d got %0d", exp_w.last, fill.last);
					end
				end
			end
			if (long_stall) begin
				fill.ready <= 1'b0;
			end else if (stall > 0) begin
				fill.ready <= 1'b0;
				stall--;
			end else begin
				fill.ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((hit.valid && hit.ready) || (fill.valid && fill.ready) || (cfg.valid && cfg.ready)
			|| long_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_WINDOW: win_ps = value;
			REG_SLOPE:  slope_q16 = value[16:0];
			REG_SHIFT:  shift_q16 = value[30:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (hit_queue.size() == 0);
		@(posedge clk);
		while (hit.valid || fill_expected.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic push_hit(logic [63:0] t, logic [2:0] ch, logic [14:0] q);
		hit_word_t h;
		h.hit_time = t;
		h.hit_channel = ch;
		h.hit_charge = q;
		hit_queue = {hit_queue, h};
	endtask

	// well-formed bursts: close groups, mostly three distinct channels or pairs
	task automatic random_bursts(int count, inout logic [63:0] t);
		int k;
		int n;
		int j;
		logic [2:0] chs [3];
		k = 0;
		while (k < count) begin
			n = $urandom_range(1, 5);
			chs[0] = 3'd0; chs[1] = 3'd2; chs[2] = 3'd4;
			for (j = 0; j < n; j++) begin
				logic [2:0] ch;
				if ($urandom_range(0, 7) == 0)
					ch = 3'($urandom_range(0, 7));
				else if (n == 3)
					ch = chs[(j + k) % 3];
				else
					ch = 3'(2 * $urandom_range(0, 2));
				push_hit(t, ch, 15'($urandom));
				t = t + 64'($urandom_range(0, win_ps > 4 ? win_ps / 4 : 1));
				k++;
			end
			t = t + 64'(win_ps) + 64'($urandom_range(0, 1000));
		end
	endtask

	logic [63:0] t_now;
	initial begin
		cfg.valid = 1'b0;
		cfg.index = REG_WINDOW;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, pair, triple, full buffer, zero window, wrap
		write_reg(REG_WINDOW, 32'd1000);
		push_hit(64'd0, 3'd0, 15'h7FFF);
		push_hit(64'd10, 3'd2, 15'd0);
		push_hit(64'd2000, 3'd4, 15'h5555);
		push_hit(64'd2001, 3'd2, 15'h2AAA);
		push_hit(64'd2002, 3'd0, 15'h7FFF);
		push_hit(64'd5000, 3'd7, 15'd1);
		push_hit(64'd5001, 3'd6, 15'd2);
		push_hit(64'd5002, 3'd5, 15'd3);
		push_hit(64'd5003, 3'd1, 15'd4);
		push_hit(64'd5004, 3'd3, 15'd5);
		push_hit(64'hFFFF_FFFF_FFFF_FFF0, 3'd2, 15'd100);
		push_hit(64'd7, 3'd4, 15'd200);
		drain();
		write_reg(REG_WINDOW, 32'd0);
		write_reg(REG_SLOPE, 32'h1FFFF);
		write_reg(REG_SHIFT, 32'h7FFFFFFF);
		push_hit(64'd100, 3'd4, 15'h7FFF);
		push_hit(64'd100, 3'd2, 15'h7FFF);
		push_hit(64'd100, 3'd0, 15'd0);
		drain();
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		write_reg(REG_SLOPE, 32'd0);
		write_reg(REG_SHIFT, 32'd0);
		push_hit(64'd0, 3'd0, 15'd9);
		push_hit(64'hFFFF_FFFF, 3'd2, 15'd8);
		push_hit(64'h1_0000_0000, 3'd4, 15'd7);
		push_hit(64'h8000_0000_0000_0000, 3'd0, 15'd6);
		drain();

		// random phase with long receiver stall
		write_reg(REG_WINDOW, 32'd400000);
		write_reg(REG_SLOPE, 32'd26951);
		write_reg(REG_SHIFT, 32'd12000625);
		t_now = 64'($urandom) << 20;
		long_stall = 1'b1;
		random_bursts(40, t_now);
		repeat (600) @(posedge clk);
		long_stall = 1'b0;
		drain();

		// sender held off while a batch of hits is queued, then released
		hold_sender = 1'b1;
		random_bursts(20, t_now);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		drain();

		write_reg(REG_WINDOW, $urandom);
		write_reg(REG_SLOPE, $urandom_range(0, 131071));
		write_reg(REG_SHIFT, $urandom & 32'h7FFFFFFF);
		t_now = {$urandom, $urandom};
		random_bursts(35, t_now);
		drain();

		write_reg(REG_WINDOW, $urandom_range(0, 5000));
		random_bursts(35, t_now);
		for (int i = 0; i < 6; i++)
			push_hit({$urandom, $urandom}, 3'($urandom_range(0, 7)), 15'($urandom));
		drain();

		$display("covered %0d hits, %0d fill words, %0d pair and %0d triple groups",
			hits_sent, fills_seen, pairs_seen, triples_seen);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
